// File: hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// File: hdl/swmf_pkg.sv
// shared types and constants of the square window median filter
`default_nettype none
package swmf_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_SIDE       = 8;
  localparam int PIX_W          = 8;
  localparam int ROW_W          = 12;
  localparam int COL_W          = 10;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int RAD_W          = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int EXT_W          = 14;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_BDATA,
    S_FETCH,
    S_FLUSH,
    S_START,
    S_SELECT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic start;
  } sel_ctrl_t;
endpackage
`default_nettype wire

// File: hdl/square_window_median_filter.sv
// top level of the square window median filter
// Streams 8-bit grey pixels in raster order and returns the median of the
// (2r+1)x(2r+1) window around each pixel; pixels within r of a frame edge pass
// through unchanged. An input request with tuser=0 carries a pixel; output
// pixel i leaves after input pixel i+r*W+r. A request with tuser=1 drains one
// pending pixel of the frame tail once the whole frame is in. The last
// 2*MAX_RADIUS+1 rows live in a single-port-read ring memory. Rate: one request
// per cycle when it causes no output, else the next waits until S_OUT is done.
// A border pixel passes S_EMIT, S_BDATA and S_OUT; an interior pixel takes
// (2r+1)^2 memory reads, then 8 selection passes over the window buffer of
// (2*MAX_RADIUS+1)^2 slots; the read port and one-compare-per-cycle selection
// set the pace. A width, height or radius write restarts the frame.
`default_nettype none
`include "assert_macros.svh"
module square_window_median_filter import swmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] pixel_in
  input  wire logic                  s_tuser,   // [0] command
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [31:0]           m_tdata,   // [7:0] pixel_out, [19:8] out_row,
                                                // [29:20] out_col, [31:30] zero
  output logic                       m_tlast,   // frame_last
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int WIN   = RING * RING;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(RING);
  localparam int AW    = SW + CW;
  localparam int DEPTH = RING * (2 ** CW);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DW    = $clog2(2 * MAX_RADIUS + 1);
  localparam int KW    = $clog2(WIN + 1);

  // configuration registers
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [RAD_W-1:0] window_radius;

  // effective, saturated settings
  logic [EXT_W-1:0] w_eff;
  logic [EXT_W-1:0] h_eff;
  logic [RW-1:0]    r_eff;
  logic [EXT_W-1:0] r_ext;

  // positions
  logic [ROW_W-1:0] in_row;
  logic [CW-1:0]    in_col;
  logic [SW-1:0]    in_slot;
  logic [ROW_W-1:0] emit_row;
  logic [CW-1:0]    emit_col;
  logic [SW-1:0]    emit_slot;
  logic             tail_open;

  // window fetch
  logic [SW-1:0]    fslot;
  logic [CW-1:0]    fcol;
  logic [CW-1:0]    fcol0;
  logic [DW-1:0]    dr;
  logic [DW-1:0]    dc;
  logic [DW-1:0]    side;
  logic             rd_pending;

  state_t           state;
  state_t           state_next;

  logic             accept;
  logic             cfg_write;
  logic             emit_due;
  logic             border;
  logic             out_free;
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_data;
  logic [SW-1:0]    base_slot;
  logic [KW-1:0]    kth;
  logic             last_pix;
  sel_ctrl_t        sel_ctrl;
  logic             sel_done;
  logic [PIX_W-1:0] sel_result;
  logic [PIX_W-1:0] res_pix;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && (s_tuser == CMD_PIXEL);
  assign out_free  = !m_tvalid || m_tready;

  // saturate the settings
  always_comb begin
    if (EXT_W'(frame_width) < EXT_W'(MIN_SIDE)) begin
      w_eff = EXT_W'(MIN_SIDE);
    end else if (EXT_W'(frame_width) > EXT_W'(MAX_WIDTH)) begin
      w_eff = EXT_W'(MAX_WIDTH);
    end else begin
      w_eff = EXT_W'(frame_width);
    end
    if (EXT_W'(frame_height) < EXT_W'(MIN_SIDE)) begin
      h_eff = EXT_W'(MIN_SIDE);
    end else if (EXT_W'(frame_height) > EXT_W'(MAX_HEIGHT)) begin
      h_eff = EXT_W'(MAX_HEIGHT);
    end else begin
      h_eff = EXT_W'(frame_height);
    end
    if (window_radius == '0) begin
      r_eff = RW'(1);
    end else if (int'(window_radius) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(window_radius);
    end
  end

  assign r_ext = EXT_W'(r_eff);
  assign side  = DW'({r_eff, 1'b0});
  assign kth   = KW'(2 * int'(r_eff) * (int'(r_eff) + 1));

  // input pixel i+r*W+r releases output pixel i
  assign emit_due = (EXT_W'(in_row) > r_ext) ||
                    ((EXT_W'(in_row) == r_ext) && (EXT_W'(in_col) >= r_ext));

  assign border = (EXT_W'(emit_row) < r_ext) ||
                  (EXT_W'(emit_row) + r_ext >= h_eff) ||
                  (EXT_W'(emit_col) < r_ext) ||
                  (EXT_W'(emit_col) + r_ext >= w_eff);

  assign last_pix = (EXT_W'(emit_row) == h_eff - EXT_W'(1)) &&
                    (EXT_W'(emit_col) == w_eff - EXT_W'(1));

  // ring slot of the top window row
  always_comb begin
    if (SW'(emit_slot) >= SW'(r_eff)) begin
      base_slot = emit_slot - SW'(r_eff);
    end else begin
      base_slot = SW'(int'(emit_slot) + RING - int'(r_eff));
    end
  end
  assign fcol0 = emit_col - CW'(r_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = {emit_slot, emit_col};
    sel_ctrl   = '0;
    sel_ctrl.push = rd_pending;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == CMD_PIXEL) begin
            if (emit_due) begin
              state_next = S_EMIT;
            end
          end else if (tail_open) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (border) begin
          rd_en      = 1'b1;
          state_next = S_BDATA;
        end else begin
          sel_ctrl.clear = 1'b1;
          state_next     = S_FETCH;
        end
      end
      S_BDATA: begin
        state_next = S_OUT;
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = {fslot, fcol};
        if (dr == side && dc == side) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_START;
      end
      S_START: begin
        sel_ctrl.start = 1'b1;
        state_next     = S_SELECT;
      end
      S_SELECT: begin
        if (sel_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_W'(512);
      frame_height  <= FH_W'(512);
      window_radius <= RAD_W'(3);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WIDTH:  frame_width   <= cfg_data[FW_W-1:0];
        CFG_HEIGHT: frame_height  <= cfg_data[FH_W-1:0];
        CFG_RADIUS: window_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // input and emit positions
  always_ff @(posedge clk) begin
    if (rst || (cfg_write && cfg_index != CFG_NONE)) begin
      in_row    <= '0;
      in_col    <= '0;
      in_slot   <= '0;
      emit_row  <= '0;
      emit_col  <= '0;
      emit_slot <= '0;
      tail_open <= 1'b0;
    end else begin
      if (wr_en) begin
        // first pixel of a frame drops any pending tail
        if (in_row == '0 && in_col == '0) begin
          emit_row  <= '0;
          emit_col  <= '0;
          emit_slot <= '0;
          tail_open <= 1'b0;
        end
        if (EXT_W'(in_col) + EXT_W'(1) >= w_eff) begin
          in_col <= '0;
          if (EXT_W'(in_row) + EXT_W'(1) >= h_eff) begin
            in_row    <= '0;
            in_slot   <= '0;
            tail_open <= 1'b1;
          end else begin
            in_row  <= in_row + ROW_W'(1);
            in_slot <= (int'(in_slot) == RING - 1) ? '0 : in_slot + SW'(1);
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (state == S_OUT && out_free) begin
        if (last_pix) begin
          emit_row  <= '0;
          emit_col  <= '0;
          emit_slot <= '0;
          tail_open <= 1'b0;
        end else if (EXT_W'(emit_col) + EXT_W'(1) >= w_eff) begin
          emit_col  <= '0;
          emit_row  <= emit_row + ROW_W'(1);
          emit_slot <= (int'(emit_slot) == RING - 1) ? '0 : emit_slot + SW'(1);
        end else begin
          emit_col <= emit_col + CW'(1);
        end
      end
    end
  end

  // window address walk, row by row
  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      fslot <= base_slot;
      fcol  <= fcol0;
      dr    <= '0;
      dc    <= '0;
    end else if (state == S_FETCH) begin
      if (dc == side) begin
        dc    <= '0;
        dr    <= dr + DW'(1);
        fcol  <= fcol0;
        fslot <= (int'(fslot) == RING - 1) ? '0 : fslot + SW'(1);
      end else begin
        dc   <= dc + DW'(1);
        fcol <= fcol + CW'(1);
      end
    end
  end

  // read data of a fetch arrives in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= (state == S_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BDATA) begin
      res_pix <= rd_data;
    end else if (state == S_SELECT && sel_done) begin
      res_pix <= sel_result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {2'b00, COL_W'(emit_col), emit_row, res_pix};
      m_tlast <= last_pix;
    end
  end

  swmf_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr ({in_slot, in_col}),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  swmf_select #(
    .WIN (WIN),
    .KW  (KW)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sel_ctrl),
    .push_data (rd_data),
    .k         (kth),
    .done      (sel_done),
    .result    (sel_result)
  );

  `ASSERT_CLK(in_col_range, (EXT_W'(in_col) < w_eff), "input column beyond frame width")
  `ASSERT_CLK(emit_col_range, (EXT_W'(emit_col) < w_eff), "emit column beyond frame width")
  `ASSERT_CLK(sel_done_in_select, (sel_done |-> state == S_SELECT), "selection done out of turn")
endmodule
`default_nettype wire

// File: hdl/swmf_store.sv
// row ring memory, one write and one registered read port
`default_nettype none
`include "assert_macros.svh"
module swmf_store import swmf_pkg::*; #(
  parameter int AW    = 13,
  parameter int DEPTH = 8192
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [PIX_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [PIX_W-1:0] rd_data
);
  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // the sequencer never reads the row it is writing in the same cycle
  `ASSERT_NEVER(no_rw_collide, wr_en && rd_en && (wr_addr == rd_addr), "store read/write collision")
endmodule
`default_nettype wire

// File: hdl/swmf_select.sv
// window buffer and bit-serial radix selection of the k-th smallest value
`default_nettype none
module swmf_select import swmf_pkg::*; #(
  parameter int WIN = 49,
  parameter int KW  = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sel_ctrl_t        ctrl,
  input  wire logic [PIX_W-1:0] push_data,
  input  wire logic [KW-1:0]    k,
  output logic                  done,
  output logic      [PIX_W-1:0] result
);
  localparam int STW = $clog2(WIN);

  logic [PIX_W-1:0] buffer [WIN];
  logic [WIN-1:0]   vld;
  logic             running;
  logic [2:0]       bitpos;
  logic [STW-1:0]   step;
  logic [KW-1:0]    cnt;
  logic [KW-1:0]    krem;
  logic [PIX_W-1:0] prefix;
  logic [PIX_W-1:0] mask;
  logic             match;
  logic [KW-1:0]    total;

  assign mask  = 8'hFF << bitpos;
  assign match = vld[0] && (((buffer[0] ^ prefix) & mask) == 8'h00);
  assign total = cnt + KW'(match);

  // buffer shifts in on push and rotates while selecting
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      for (int i = 0; i < WIN - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
      buffer[WIN-1] <= push_data;
    end else if (running) begin
      for (int i = 0; i < WIN - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
      buffer[WIN-1] <= buffer[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      vld <= '0;
    end else if (ctrl.push) begin
      vld <= {1'b1, vld[WIN-1:1]};
    end else if (running) begin
      vld <= {vld[0], vld[WIN-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= !ctrl.start && running && step == STW'(WIN - 1) && bitpos == 3'd0;
      if (ctrl.start) begin
        running <= 1'b1;
      end else if (running && step == STW'(WIN - 1) && bitpos == 3'd0) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bitpos <= 3'd7;
      step   <= '0;
      cnt    <= '0;
      krem   <= k;
      prefix <= '0;
    end else if (running) begin
      if (step == STW'(WIN - 1)) begin
        // end of a pass: settle one bit of the answer
        step <= '0;
        cnt  <= '0;
        if (krem >= total) begin
          prefix[bitpos] <= 1'b1;
          krem           <= krem - total;
        end
        bitpos <= bitpos - 3'd1;
      end else begin
        step <= step + STW'(1);
        cnt  <= total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running && step == STW'(WIN - 1) && bitpos == 3'd0) begin
      result <= {prefix[PIX_W-1:1], (krem >= total)};
    end
  end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// testbench of the square window median filter: stream checks against a behavioral predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import swmf_pkg::*;

  localparam int RING_ROWS = 2 * MAX_RADIUS_DEF + 1;
  // longest time the block may still be busy after its last result
  localparam int SETTLE_CYCLES = 600;

  typedef struct {
    logic [7:0]  pix;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } out_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input stream
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] pixel_in
  logic        s_tuser = 1'b0; // [0] command
  // output stream
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
  logic        m_tlast;        // frame_last
  // configuration channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  square_window_median_filter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state: raw register values, ring of rows, raster positions
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [1:0]  radius_reg;
  logic [7:0]  ring_mem [RING_ROWS * MAX_WIDTH_DEF];
  int          in_row, in_col, emit_row, emit_col;
  bit          tail_open;

  out_pixel_t expected_pixels[$];
  int  error_count = 0;
  int  pixels_sent = 0;
  bit  no_idle = 1'b0;
  int  hold_cycles = 0;

  function automatic int eff_width();
    return (width_reg < MIN_SIDE) ? MIN_SIDE :
           (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg < MIN_SIDE) ? MIN_SIDE :
           (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  function automatic int eff_radius();
    return (radius_reg == 0) ? 1 : int'(radius_reg);
  endfunction

  function automatic logic [7:0] ring_at(int row, int col);
    return ring_mem[(row % RING_ROWS) * MAX_WIDTH_DEF + (col % MAX_WIDTH_DEF)];
  endfunction

  // median of the window, or the stored pixel itself near an edge
  function automatic logic [7:0] median_at(int er, int ec);
    int w, h, r, n, j;
    logic [7:0] vals [49];
    logic [7:0] v;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    n = 0;
    if (er < r || er + r >= h || ec < r || ec + r >= w) return ring_at(er, ec);
    for (int dr = -r; dr <= r; dr++)
      for (int dc = -r; dc <= r; dc++) begin
        vals[n] = ring_at(er + dr, ec + dc);
        n++;
      end
    for (int i = 1; i < n; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return vals[(n - 1) / 2];
  endfunction

  function automatic void queue_next_pixel();
    out_pixel_t o;
    int w, h;
    w = eff_width();
    h = eff_height();
    o.last = (emit_row == h - 1) && (emit_col == w - 1);
    o.pix  = median_at(emit_row, emit_col);
    o.row  = emit_row[11:0];
    o.col  = emit_col[9:0];
    expected_pixels.push_back(o);
    emit_col++;
    if (emit_col >= w) begin
      emit_col = 0;
      emit_row++;
    end
    if (o.last) begin
      emit_row = 0;
      emit_col = 0;
      tail_open = 1'b0;
    end
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    emit_row = 0;
    emit_col = 0;
    tail_open = 1'b0;
  endfunction

  // one accepted input request
  function automatic void predict_request(logic cmd, logic [7:0] pix);
    int w, h, r;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    if (cmd == CMD_DRAIN) begin
      if (tail_open) queue_next_pixel();
      return;
    end
    // first pixel of a frame drops any pending tail
    if (in_row == 0 && in_col == 0) begin
      emit_row = 0;
      emit_col = 0;
      tail_open = 1'b0;
    end
    ring_mem[(in_row % RING_ROWS) * MAX_WIDTH_DEF + in_col] = pix;
    if (in_row * w + in_col >= r * w + r) queue_next_pixel();
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) begin
        in_row = 0;
        tail_open = 1'b1;
      end
    end
  endfunction

  // accepted requests and register writes feed the predictor
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = 11'd512;
      height_reg = 13'd512;
      radius_reg = 2'd3;
      restart_frame();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH: begin
            width_reg = cfg_data[10:0];
            restart_frame();
          end
          CFG_HEIGHT: begin
            height_reg = cfg_data[12:0];
            restart_frame();
          end
          CFG_RADIUS: begin
            radius_reg = cfg_data[1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_request(s_tuser, s_tdata);
        if (s_tuser == CMD_PIXEL) pixels_sent++;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_pixel_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel, actual data=%h last=%b",
                 $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        e = expected_pixels.pop_front();
        if (m_tdata[7:0] !== e.pix || m_tdata[19:8] !== e.row ||
            m_tdata[29:20] !== e.col || m_tlast !== e.last) begin
          $display("%0t: mismatch expected pix=%0d row=%0d col=%0d last=%b",
                   $time, e.pix, e.row, e.col, e.last);
          $display("%0t:          actual   pix=%0d row=%0d col=%0d last=%b",
                   $time, m_tdata[7:0], m_tdata[19:8], m_tdata[29:20], m_tlast);
          error_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(0, 99) >= 38);
    end
  end

  // one input request; valid stays high for a following request
  task automatic send_request(logic cmd, logic [7:0] pix);
    while (!no_idle && $urandom_range(0, 99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= pix;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int value);
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every output has come and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int r);
    settle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RADIUS, r);
  endtask

  // pixel styles: 0 random, 1 salt and pepper, 2 smooth ramp, 3 extremes
  function automatic logic [7:0] make_pixel(int style, int k);
    case (style)
      1: return ($urandom_range(0, 9) < 2) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                          : 8'(100 + $urandom_range(0, 20));
      2: return 8'(k * 3);
      3: return (k % 3 == 0) ? 8'hff : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // full frame of npix pixels, stray drains mixed in, then the tail drains
  task automatic send_frame(int npix, int style, int stray_pct, int tail_drains);
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(0, 99) < stray_pct) send_request(CMD_DRAIN, 8'($urandom));
      send_request(CMD_PIXEL, make_pixel(style, k));
    end
    for (int k = 0; k < tail_drains; k++) send_request(CMD_DRAIN, 8'($urandom));
  endtask

  task automatic run_full_frame(int w, int h, int r, int style);
    int ew, eh, er;
    ew = (w < 8) ? 8 : (w > 1024) ? 1024 : w;
    eh = (h < 8) ? 8 : (h > 4096) ? 4096 : h;
    er = (r == 0) ? 1 : r;
    configure(w, h, r);
    send_frame(ew * eh, style, 5, er * ew + er);
  endtask

  // drain before any frame has arrived, under the reset settings
  task automatic test_reset_drain();
    for (int k = 0; k < 4; k++) send_request(CMD_DRAIN, 8'hff);
    for (int k = 0; k < 6; k++) send_request(CMD_PIXEL, 8'(k));
    send_request(CMD_DRAIN, 8'h00);
  endtask

  // smallest frames at each radius, with extreme, ramp and random pixel values
  task automatic test_directed();
    run_full_frame(8, 8, 1, 3);
    send_request(CMD_DRAIN, 8'h00);   // tail already flushed
    run_full_frame(8, 8, 2, 2);
    run_full_frame(8, 8, 3, 3);
    configure(8, 8, 1);
    send_frame(64, 0, 0, 0);
    send_request(CMD_PIXEL, 8'hff);   // tail pending: dropped, new frame starts
    send_frame(63, 1, 0, 9);
  endtask

  // out-of-range registers saturate; unused index is ignored
  task automatic test_saturation();
    run_full_frame(0, 0, 0, 0);
    configure(2047, 8191, 1);
    write_reg(CFG_NONE, 8191);
    // only the first 12 pixels of row 0 leave before the next write cuts the frame
    send_frame(1024 + 1 + 12, 0, 0, 0);
    // write in the middle of a frame restarts it
    configure(10, 8, 1);
    send_frame(40, 0, 0, 0);
    settle();
    write_reg(CFG_RADIUS, 2);
    send_frame(80, 0, 0, 2 * 10 + 2);
  endtask

  // receiver holds off while the sender keeps pushing; then a sender pause
  task automatic test_backpressure();
    configure(16, 8, 1);
    hold_cycles = 3000;
    no_idle = 1'b1;
    send_frame(128, 0, 0, 17);
    no_idle = 1'b0;
    configure(12, 9, 1);
    send_frame(60, 1, 0, 0);
    settle();
    send_frame(48, 1, 0, 13);
  endtask

  task automatic test_random();
    int w, h, r, npix;
    while (pixels_sent < 1900) begin
      w = $urandom_range(8, 20);
      h = $urandom_range(8, 12);
      r = $urandom_range(0, 3);
      npix = w * h;
      configure(w, h, r);
      no_idle = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) < 8) begin
        send_frame(npix, $urandom_range(0, 3), 3, ((r == 0) ? 1 : r) * (w + 1));
        if ($urandom_range(0, 3) == 0) send_request(CMD_DRAIN, 8'($urandom));
      end else begin
        // broken frame: cut short, stray drains
        send_frame($urandom_range(1, npix - 1), 0, 20, $urandom_range(0, 5));
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_drain();
    test_directed();
    test_saturation();
    test_backpressure();
    test_random();
    settle();
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_pixels.size() != 0)
        $display("%0t: %0d expected pixels never came out", $time, expected_pixels.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+hdl
hdl/swmf_pkg.sv
hdl/swmf_store.sv
hdl/swmf_select.sv
hdl/square_window_median_filter.sv
tb/tb_top.sv
